// ----- sv/cse_pkg.sv -----
package cse_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // The gap shrinks as gap * 10 / 13. The division by 13 is a multiply by
    // ceil(2^16 / 13) and a shift, exact for every scaled gap below 2^11.
    localparam int SHRINK_NUM   = 10;
    localparam int SHRINK_RECIP = 5042;
    localparam int SHRINK_SHIFT = 16;
    localparam int RECIP_W      = 13;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_SHRINK,
        OP_RD_I,
        OP_RD_J,
        OP_LATCH_B,
        OP_WR_I,
        OP_WR_J,
        OP_INC_I,
        OP_OUT_INIT,
        OP_OUT_LOAD,
        OP_CLEAR
    } t_dp_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_LOAD_WAIT,
        COND_SORTED,
        COND_PASS_END,
        COND_NO_SWAP,
        COND_OUT_HOLD,
        COND_OUT_MORE
    } t_cond;

    typedef logic [4:0] t_upc;

    localparam t_upc UPC_LOAD     = 5'd0;
    localparam t_upc UPC_INIT     = 5'd1;
    localparam t_upc UPC_CHECK    = 5'd2;
    localparam t_upc UPC_SHRINK   = 5'd3;
    localparam t_upc UPC_TEST     = 5'd4;
    localparam t_upc UPC_RD_I     = 5'd5;
    localparam t_upc UPC_RD_J     = 5'd6;
    localparam t_upc UPC_CMP      = 5'd7;
    localparam t_upc UPC_WR_I     = 5'd8;
    localparam t_upc UPC_WR_J     = 5'd9;
    localparam t_upc UPC_NEXT     = 5'd10;
    localparam t_upc UPC_OUT_INIT = 5'd11;
    localparam t_upc UPC_OUT_RD   = 5'd12;
    localparam t_upc UPC_OUT_LD   = 5'd13;
    localparam t_upc UPC_OUT_WAIT = 5'd14;
    localparam t_upc UPC_OUT_MORE = 5'd15;
    localparam t_upc UPC_CLEAR    = 5'd16;

    typedef struct packed {
        t_dp_op op;
        t_cond  cond;
        t_upc   target;
    } t_uop;

    typedef struct packed {
        logic load_wait;
        logic sorted;
        logic pass_end;
        logic no_swap;
        logic out_hold;
        logic out_more;
    } t_seq_flags;

    // Control store. When the condition holds the step jumps to its target,
    // otherwise it falls through to the next step.
    function automatic t_uop uop_rom(input t_upc upc);
        t_uop w;
        case (upc)
            UPC_LOAD:     w = '{op: OP_LOAD,     cond: COND_LOAD_WAIT, target: UPC_LOAD};
            UPC_INIT:     w = '{op: OP_INIT,     cond: COND_NEXT,      target: UPC_LOAD};
            UPC_CHECK:    w = '{op: OP_NOP,      cond: COND_SORTED,    target: UPC_OUT_INIT};
            UPC_SHRINK:   w = '{op: OP_SHRINK,   cond: COND_NEXT,      target: UPC_LOAD};
            UPC_TEST:     w = '{op: OP_NOP,      cond: COND_PASS_END,  target: UPC_CHECK};
            UPC_RD_I:     w = '{op: OP_RD_I,     cond: COND_NEXT,      target: UPC_LOAD};
            UPC_RD_J:     w = '{op: OP_RD_J,     cond: COND_NEXT,      target: UPC_LOAD};
            UPC_CMP:      w = '{op: OP_LATCH_B,  cond: COND_NO_SWAP,   target: UPC_NEXT};
            UPC_WR_I:     w = '{op: OP_WR_I,     cond: COND_NEXT,      target: UPC_LOAD};
            UPC_WR_J:     w = '{op: OP_WR_J,     cond: COND_NEXT,      target: UPC_LOAD};
            UPC_NEXT:     w = '{op: OP_INC_I,    cond: COND_ALWAYS,    target: UPC_TEST};
            UPC_OUT_INIT: w = '{op: OP_OUT_INIT, cond: COND_NEXT,      target: UPC_LOAD};
            UPC_OUT_RD:   w = '{op: OP_RD_I,     cond: COND_NEXT,      target: UPC_LOAD};
            UPC_OUT_LD:   w = '{op: OP_OUT_LOAD, cond: COND_NEXT,      target: UPC_LOAD};
            UPC_OUT_WAIT: w = '{op: OP_NOP,      cond: COND_OUT_HOLD,  target: UPC_OUT_WAIT};
            UPC_OUT_MORE: w = '{op: OP_NOP,      cond: COND_OUT_MORE,  target: UPC_OUT_RD};
            UPC_CLEAR:    w = '{op: OP_CLEAR,    cond: COND_ALWAYS,    target: UPC_LOAD};
            default:      w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: UPC_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/comb_sort_engine.sv -----
// Channel   Direction  Signals                              Contents
// s_axis    in         tvalid tready tdata tlast            tdata: value; tlast: last
// m_axis    out        tvalid tready tdata tlast tuser      tdata: sorted_value;
//                                                           tlast: last_out; tuser: overflow
//
// Loading accepts one value per cycle. After the last value each comb compare
// reads both entries and, when the pair is swapped, writes both back; each pass
// ends with a sorted check and, unless the set is sorted, a gap shrink. Each
// result is then read through the single read port of the entry store. The sort
// makes about log(N)/log(1.3) passes of up to N compares.
// Reset is synchronous and active low and clears the control state only.
// A stalled master side holds the sequencer in its wait step.
module comb_sort_engine #(
    parameter int DEPTH       = cse_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = cse_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // value
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,   // sorted_value
    output logic                                 m_axis_tlast,
    output logic [0:0]                           m_axis_tuser    // overflow
);

    import cse_pkg::*;

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    t_dp_op                 w_op;
    t_seq_flags             w_flags;
    logic [VALUE_WIDTH-1:0] w_out_value;
    logic                   w_out_ovf;

    cse_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    cse_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .o_flags        (w_flags),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_in_value     (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_in_last      (s_axis_tlast),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_value    (w_out_value),
        .o_out_last     (m_axis_tlast),
        .o_out_overflow (w_out_ovf)
    );

    assign m_axis_tdata = TDATA_W'(w_out_value);
    assign m_axis_tuser = w_out_ovf;

endmodule

// ----- sv/cse_ram.sv -----
module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/cse_dp.sv -----
module cse_dp #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cse_pkg::t_dp_op        i_op,
    output cse_pkg::t_seq_flags    o_flags,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_in_value,
    input  logic                   i_in_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_out_value,
    output logic                   o_out_last,
    output logic                   o_out_overflow
);

    import cse_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SCALE_W = CNT_W + 4;
    localparam int PROD_W  = SCALE_W + RECIP_W;

    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_gap, n_gap;
    logic [CNT_W-1:0]       r_i, n_i;
    logic                   r_swap, n_swap;
    logic                   r_dropped, n_dropped;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_a, n_a;
    logic [VALUE_WIDTH-1:0] r_b, n_b;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic                   r_out_last, n_out_last;
    logic                   r_out_ovf, n_out_ovf;

    logic                   w_in_acc;
    logic                   w_full;
    logic [CNT_W:0]         w_j;
    logic [CNT_W:0]         w_i_inc;
    logic [SCALE_W-1:0]     w_scaled;
    logic [PROD_W-1:0]      w_prod;
    logic [CNT_W-1:0]       w_shrunk;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [ADDR_W-1:0]      w_raddr;
    logic [VALUE_WIDTH-1:0] w_rdata;

    assign o_in_ready = (i_op == OP_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_j        = {1'b0, r_i} + {1'b0, r_gap};
    assign w_i_inc    = {1'b0, r_i} + (CNT_W + 1)'(1);

    assign w_scaled = SCALE_W'(r_gap) * SCALE_W'(SHRINK_NUM);
    assign w_prod   = PROD_W'(w_scaled) * PROD_W'(SHRINK_RECIP);
    assign w_shrunk = w_prod[SHRINK_SHIFT +: CNT_W];

    assign o_flags.load_wait = !(w_in_acc && i_in_last);
    assign o_flags.sorted    = (r_gap == CNT_W'(1)) && !r_swap;
    assign o_flags.pass_end  = (w_j >= {1'b0, r_count});
    assign o_flags.no_swap   = !($signed(r_a) > $signed(w_rdata));
    assign o_flags.out_hold  = r_out_valid && !i_out_ready;
    assign o_flags.out_more  = (r_i < r_count);

    // Store port steering.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i[ADDR_W-1:0];
        w_wdata = r_b;
        w_raddr = r_i[ADDR_W-1:0];
        case (i_op)
            OP_LOAD: begin
                w_we    = w_in_acc && !w_full;
                w_waddr = r_count[ADDR_W-1:0];
                w_wdata = i_in_value;
            end
            OP_RD_J: begin
                w_raddr = w_j[ADDR_W-1:0];
            end
            OP_WR_I: begin
                w_we = 1'b1;
            end
            OP_WR_J: begin
                w_we    = 1'b1;
                w_waddr = w_j[ADDR_W-1:0];
                w_wdata = r_a;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_gap       = r_gap;
        n_i         = r_i;
        n_swap      = r_swap;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_a         = r_a;
        n_b         = r_b;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (i_op)
            OP_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            OP_INIT: begin
                n_gap  = r_count;
                n_swap = 1'b1;
            end
            OP_SHRINK: begin
                n_gap  = (w_shrunk == '0) ? CNT_W'(1) : w_shrunk;
                n_swap = 1'b0;
                n_i    = '0;
            end
            OP_RD_J: begin
                n_a = w_rdata;
            end
            OP_LATCH_B: begin
                n_b = w_rdata;
            end
            OP_WR_I: begin
                n_swap = 1'b1;
            end
            OP_INC_I: begin
                n_i = w_i_inc[CNT_W-1:0];
            end
            OP_OUT_INIT: begin
                n_i = '0;
            end
            OP_OUT_LOAD: begin
                n_out_valid = 1'b1;
                n_out_value = w_rdata;
                n_out_last  = (w_i_inc == {1'b0, r_count});
                n_out_ovf   = r_dropped;
                n_i         = w_i_inc[CNT_W-1:0];
            end
            OP_CLEAR: begin
                n_count   = '0;
                n_gap     = '0;
                n_swap    = 1'b0;
                n_dropped = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_gap       <= '0;
            r_i         <= '0;
            r_swap      <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_gap       <= n_gap;
            r_i         <= n_i;
            r_swap      <= n_swap;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    cse_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_out_value    = r_out_value;
    assign o_out_last     = r_out_last;
    assign o_out_overflow = r_out_ovf;

endmodule

// ----- sv/cse_seq.sv -----
module cse_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cse_pkg::t_seq_flags i_flags,
    output cse_pkg::t_dp_op     o_op
);

    import cse_pkg::*;

    t_upc r_upc, n_upc;
    t_uop w_uop;
    logic w_take;

    assign w_uop = uop_rom(r_upc);

    always_comb begin
        case (w_uop.cond)
            COND_NEXT:      w_take = 1'b0;
            COND_ALWAYS:    w_take = 1'b1;
            COND_LOAD_WAIT: w_take = i_flags.load_wait;
            COND_SORTED:    w_take = i_flags.sorted;
            COND_PASS_END:  w_take = i_flags.pass_end;
            COND_NO_SWAP:   w_take = i_flags.no_swap;
            COND_OUT_HOLD:  w_take = i_flags.out_hold;
            COND_OUT_MORE:  w_take = i_flags.out_more;
            default:        w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = w_take ? w_uop.target : r_upc + t_upc'(1);
    end

    always_comb begin
        o_op = w_uop.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_LOAD;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ----- tb/sv/comb_sort_engine_tb.sv -----
`timescale 1ns / 1ps

module comb_sort_engine_tb;
    import cse_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int VALUE_WIDTH  = VALUE_WIDTH_DEFAULT;
    localparam int TDATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int TARGET_ITEMS = 210;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct {
        t_value value;
        logic   last;
        logic   overflow;
    } t_sorted_item;

    // Keeps the values of the open set and the sorted results still owed by the block.
    class sorted_set_checker;
        t_value       held_values[$];
        bit           dropped;
        t_sorted_item expected_sorted[$];
        int unsigned  mismatches;

        function new();
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        function void note_value(t_value v, logic last);
            t_sorted_item item;
            t_value       tmp;
            int           gap;
            int           n;
            bit           swapped;
            if (held_values.size() < DEPTH)
                held_values.push_back(v);
            else
                dropped = 1'b1;
            if (!last)
                return;
            // Comb sort with shrink factor 10/13; passes end once the gap is 1
            // and nothing moved.
            n       = held_values.size();
            gap     = n;
            swapped = 1'b1;
            while (gap != 1 || swapped) begin
                gap = (gap * 10) / 13;
                if (gap < 1)
                    gap = 1;
                swapped = 1'b0;
                for (int i = 0; i + gap < n; i++) begin
                    if (held_values[i] > held_values[i + gap]) begin
                        tmp                  = held_values[i];
                        held_values[i]       = held_values[i + gap];
                        held_values[i + gap] = tmp;
                        swapped              = 1'b1;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                item.value    = held_values[k];
                item.last     = (k == n - 1);
                item.overflow = dropped;
                expected_sorted.push_back(item);
            end
            held_values.delete();
            dropped = 1'b0;
        endfunction

        function void check_sorted(logic [TDATA_W-1:0] data, logic last, logic overflow);
            t_sorted_item item;
            if (expected_sorted.size() == 0) begin
                $error("sorted_value: expected none, actual %0d",
                       t_value'(data[VALUE_WIDTH-1:0]));
                mismatches++;
                return;
            end
            item = expected_sorted.pop_front();
            if (data[VALUE_WIDTH-1:0] !== item.value) begin
                $error("sorted_value: expected %0d, actual %0d",
                       item.value, t_value'(data[VALUE_WIDTH-1:0]));
                mismatches++;
            end
            if (last !== item.last) begin
                $error("last_out: expected %0b, actual %0b", item.last, last);
                mismatches++;
            end
            if (overflow !== item.overflow) begin
                $error("overflow: expected %0b, actual %0b", item.overflow, overflow);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;   // value
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;         // sorted_value
    logic               m_axis_tlast;
    logic [0:0]         m_axis_tuser;         // overflow

    sorted_set_checker sorted_check = new();
    bit                calm         = 1'b0;
    int                items_sent   = 0;

    comb_sort_engine #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_wait();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic send_value(input t_value v, input logic last);
        int idle;
        idle = pick_wait();
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(unsigned'(v));
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sorted_check.note_value(v, last);
        items_sent++;
    endtask

    // Holds the input side until the block has delivered every owed result.
    task automatic drain_results();
        if (sorted_check.expected_sorted.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            while (sorted_check.expected_sorted.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = pick_wait();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sorted_check.check_sorted(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
    end

    initial begin : stimulus
        int set_len;
        int set_no;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the value range in one set.
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b1);
        // A set of one value.
        send_value(32'h8000_0000, 1'b1);
        // Equal values in one set.
        send_value(5, 1'b0);
        send_value(5, 1'b0);
        send_value(-5, 1'b0);
        send_value(5, 1'b1);
        // Descending input, then input that is already in order.
        for (int k = 7; k >= 0; k--)
            send_value((k - 4) * 1000003, k == 0);
        for (int k = -2; k <= 1; k++)
            send_value(k, k == 1);

        drain_results();

        // Mostly short sets; one exactly fills the store and one runs past it,
        // so that both a plain value and the closing value are dropped.
        set_no = 0;
        while (items_sent < TARGET_ITEMS) begin
            set_len = (set_no == 1) ? DEPTH :
                      (set_no == 4) ? DEPTH + 2 : $urandom_range(1, 16);
            calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < set_len; k++)
                send_value(($urandom_range(0, 3) == 0) ?
                           t_value'($urandom_range(0, 8)) - t_value'(4) :
                           t_value'($urandom), k == set_len - 1);
            if ($urandom_range(0, 3) == 0)
                drain_results();
            set_no++;
        end
        calm = 1'b0;

        drain_results();
        s_axis_tvalid <= 1'b0;
        repeat (40) @(posedge i_clk);
        if (sorted_check.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Far beyond the slowest correct run, including full-depth sets under stalls.
    initial begin : watchdog
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/cse_pkg.sv
sv/cse_ram.sv
sv/cse_dp.sv
sv/cse_seq.sv
sv/comb_sort_engine.sv
tb/sv/comb_sort_engine_tb.sv
